// File: rtl/til_pkg.sv
// Shared types and constants for the timed interval locator.
// Used by til_alu, timed_interval_locator and the testbench; no dependencies.
package til_pkg;

    localparam int DEF_MAX_LINES     = 256;
    localparam int DEF_MAX_TOKENS    = 4096;
    localparam int DEF_TIME_BITS     = 32;
    localparam int DEF_PROGRESS_BITS = 16;

    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_SPAN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_LINE_SPAN = 16'd5000;
    localparam logic [CFG_DATA_W-1:0] RST_DEADBAND  = 16'd66;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_LINE   = 3'd1,
        KIND_TOKEN  = 3'd2,
        KIND_FINISH = 3'd3,
        KIND_POS    = 3'd4
    } kind_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_LRD, ST_F_LCAP, ST_F_NCAP, ST_F_LFIX, ST_F_LADD,
        ST_F_TINIT, ST_F_TRD, ST_F_TCAP, ST_F_TNCAP, ST_F_TFIX,
        ST_F_TCHK, ST_F_TADD, ST_F_TNEXT, ST_F_LNEXT,
        ST_P_LPROBE, ST_P_LCAP, ST_P_LC1, ST_P_LC2, ST_P_LHIT,
        ST_P_TPROBE, ST_P_TCAP, ST_P_TC1, ST_P_TC2,
        ST_P_DNUM, ST_P_DDEN, ST_P_DSTEP, ST_P_DTOK, ST_P_OUT
    } state_t;

endpackage

// File: rtl/til_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module til_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/til_alu.sv
// Shared add / subtract unit used by the sequencer for every time compare,
// saturating sum and divide step. Depends on til_pkg.
module til_alu #(
    parameter int W = 33
) (
    input  til_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     res,
    output logic             flag
);
    import til_pkg::*;

    logic [W:0] wide;

    always_comb
    begin
        unique case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = '0;
        endcase
    end

    // carry on add, borrow (a < b) on subtract
    assign res  = wide[W-1:0];
    assign flag = wide[W];
endmodule

// File: rtl/timed_interval_locator.sv
// Top level of the timed interval locator: sequencer, line and token tables.
// Depends on til_pkg, til_ram and til_alu.
//
// Usage: one input stream (s_tvalid/s_tready/s_tdata/s_tuser, kind in tuser)
// and one result stream (m_*). Clear, line and token transactions are applied
// on acceptance and give no result. A finish transaction sweeps the tables to
// repair missing end times, line by line and token by token. A position
// transaction gives one result after up to two binary searches (up to nine
// line probes and thirteen token probes at the default sizes), a line-hit step
// between them and a restoring progress divide. Time compares, sums and divide
// steps run through one shared add/subtract unit and single-port table reads,
// and s_tready is high only while the sequencer is idle.
// The result sits in an output register; when the receiver stalls, the next
// position transaction completes its search and waits for the register to
// drain. Reset empties the timeline and loads the register defaults
// (line span 5000 ms, deadband 66). Table contents are not cleared; only
// entries below the loaded counts are ever read.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at once.
module timed_interval_locator #(
    parameter int MAX_LINES     = til_pkg::DEF_MAX_LINES,
    parameter int MAX_TOKENS    = til_pkg::DEF_MAX_TOKENS,
    parameter int TIME_BITS     = til_pkg::DEF_TIME_BITS,
    parameter int PROGRESS_BITS = til_pkg::DEF_PROGRESS_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // time_start[31:0], time_end[63:32], token_count[76:64],
    // position_ms[108:77], zero fill
    input  logic [til_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  logic [til_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_found[0], line_index[8:1], line_changed[9], token_valid[10],
    // token_index[22:11], progress[38:23], zero fill
    output logic [til_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [til_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [til_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import til_pkg::*;

    localparam int TB  = TIME_BITS;
    localparam int PB  = PROGRESS_BITS;
    localparam int LW  = $clog2(MAX_LINES);
    localparam int TKW = $clog2(MAX_TOKENS);
    localparam int CW  = LW + 1;
    localparam int TCW = TKW + 1;
    localparam int W   = TB + 1;
    localparam int DCW = $clog2(PB);
    localparam int LWD = 2 * TB + 2 * TCW;
    localparam int TWD = 2 * TB;

    // input fields
    kind_t              in_kind;
    logic [TB-1:0]      in_start;
    logic [TB-1:0]      in_end;
    logic [COUNT_W-1:0] in_count;
    logic [TB-1:0]      in_pos;

    assign in_kind  = kind_t'(s_tuser);
    assign in_start = TB'(s_tdata[31:0]);
    assign in_end   = TB'(s_tdata[63:32]);
    assign in_count = s_tdata[76:64];
    assign in_pos   = TB'(s_tdata[108:77]);

    state_t state_reg, state_next;
    logic [CW-1:0]      lines_reg, lines_next;
    logic [TCW-1:0]     tokens_reg, tokens_next;
    logic [COUNT_W-1:0] pend_reg, pend_next;
    logic               pacc_reg, pacc_next;
    logic [15:0]        span_reg, span_next;
    logic [15:0]        dband_reg, dband_next;
    logic [LW-1:0]      cline_reg, cline_next;
    logic               clv_reg, clv_next;
    logic [TKW-1:0]     ctok_reg, ctok_next;
    logic               ctv_reg, ctv_next;
    logic [PB-1:0]      prog_reg, prog_next;
    logic [TB-1:0]      pos_reg, pos_next;
    logic [TB-1:0]      ld_start_reg, ld_start_next;
    logic [TB-1:0]      ld_end_reg, ld_end_next;
    logic [TCW-1:0]     ld_base_reg, ld_base_next;
    logic [TCW-1:0]     ld_tot_reg, ld_tot_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [LW-1:0]      mid_reg, mid_next;
    logic [TCW-1:0]     tlo_reg, tlo_next;
    logic [TCW-1:0]     thi_reg, thi_next;
    logic [TKW-1:0]     tmid_reg, tmid_next;
    logic [TB-1:0]      l_start_reg, l_start_next;
    logic [TB-1:0]      l_end_reg, l_end_next;
    logic [TCW-1:0]     l_base_reg, l_base_next;
    logic [TCW-1:0]     l_tot_reg, l_tot_next;
    logic [TB-1:0]      n_start_reg, n_start_next;
    logic [TB-1:0]      t_start_reg, t_start_next;
    logic [TB-1:0]      t_end_reg, t_end_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [TB-1:0]      den_reg, den_next;
    logic [PB-1:0]      q_reg, q_next;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;
    logic               found_reg, found_next;
    logic               chg_reg, chg_next;
    logic               mv_reg, mv_next;
    logic [OUT_DATA_W-1:0] md_reg, md_next;

    // table ports
    logic           lram_we, lram_re, tram_we, tram_re;
    logic [LW-1:0]  lram_waddr, lram_raddr;
    logic [TKW-1:0] tram_waddr, tram_raddr;
    logic [LWD-1:0] lram_wdata, lram_rdata;
    logic [TWD-1:0] tram_wdata, tram_rdata;

    til_ram #(.WIDTH(LWD), .DEPTH(MAX_LINES)) u_line_ram (
        .clk(clk), .we(lram_we), .waddr(lram_waddr), .wdata(lram_wdata),
        .re(lram_re), .raddr(lram_raddr), .rdata(lram_rdata)
    );

    til_ram #(.WIDTH(TWD), .DEPTH(MAX_TOKENS)) u_token_ram (
        .clk(clk), .we(tram_we), .waddr(tram_waddr), .wdata(tram_wdata),
        .re(tram_re), .raddr(tram_raddr), .rdata(tram_rdata)
    );

    logic [TB-1:0]  lr_start, lr_end, tr_start, tr_end;
    logic [TCW-1:0] lr_base, lr_tot;

    assign lr_start = lram_rdata[TB-1:0];
    assign lr_end   = lram_rdata[2*TB-1:TB];
    assign lr_base  = lram_rdata[2*TB+TCW-1:2*TB];
    assign lr_tot   = lram_rdata[LWD-1:2*TB+TCW];
    assign tr_start = tram_rdata[TB-1:0];
    assign tr_end   = tram_rdata[TWD-1:TB];

    alu_op_t      alu_op;
    logic [W-1:0] alu_a, alu_b, alu_res;
    logic         alu_flag;
    logic [TB-1:0] sat_sum;

    til_alu #(.W(W)) u_alu (
        .op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .flag(alu_flag)
    );

    assign sat_sum = alu_res[TB] ? {TB{1'b1}} : alu_res[TB-1:0];

    // combinational helpers
    logic [CW:0]    lmid_w;
    logic [TCW:0]   tmid_w;
    logic [CW-1:0]  lo_inc;
    logic [TCW-1:0] tlo_inc;
    logic [W-1:0]   rem2;
    logic [PB-1:0]  pdiff;
    logic [TKW-1:0] tok_addr;

    assign lmid_w   = ({1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1) >> 1;
    assign tmid_w   = ({1'b0, tlo_reg} + {1'b0, thi_reg} - 1'b1) >> 1;
    assign lo_inc   = lo_reg + 1'b1;
    assign tlo_inc  = tlo_reg + 1'b1;
    assign rem2     = {rem_reg[W-2:0], 1'b0};
    assign pdiff    = (q_reg > prog_reg) ? q_reg - prog_reg : prog_reg - q_reg;
    assign tok_addr = TKW'(l_base_reg + tlo_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb
    begin
        state_next    = state_reg;
        lines_next    = lines_reg;
        tokens_next   = tokens_reg;
        pend_next     = pend_reg;
        pacc_next     = pacc_reg;
        span_next     = span_reg;
        dband_next    = dband_reg;
        cline_next    = cline_reg;
        clv_next      = clv_reg;
        ctok_next     = ctok_reg;
        ctv_next      = ctv_reg;
        prog_next     = prog_reg;
        pos_next      = pos_reg;
        ld_start_next = ld_start_reg;
        ld_end_next   = ld_end_reg;
        ld_base_next  = ld_base_reg;
        ld_tot_next   = ld_tot_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        tlo_next      = tlo_reg;
        thi_next      = thi_reg;
        tmid_next     = tmid_reg;
        l_start_next  = l_start_reg;
        l_end_next    = l_end_reg;
        l_base_next   = l_base_reg;
        l_tot_next    = l_tot_reg;
        n_start_next  = n_start_reg;
        t_start_next  = t_start_reg;
        t_end_next    = t_end_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        q_next        = q_reg;
        dcnt_next     = dcnt_reg;
        found_next    = found_reg;
        chg_next      = chg_reg;
        mv_next       = mv_reg;
        md_next       = md_reg;

        lram_we    = 1'b0;
        lram_waddr = '0;
        lram_wdata = '0;
        lram_re    = 1'b0;
        lram_raddr = '0;
        tram_we    = 1'b0;
        tram_waddr = '0;
        tram_wdata = '0;
        tram_re    = 1'b0;
        tram_raddr = '0;
        alu_op     = ALU_SUB;
        alu_a      = '0;
        alu_b      = '0;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            if (cfg_addr == CFG_LINE_SPAN)
            begin
                span_next = cfg_wdata;
            end
            else
            begin
                dband_next = cfg_wdata;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_kind)
                        KIND_CLEAR:
                        begin
                            lines_next  = '0;
                            tokens_next = '0;
                            pend_next   = '0;
                            pacc_next   = 1'b0;
                            cline_next  = '0;
                            clv_next    = 1'b0;
                            ctok_next   = '0;
                            ctv_next    = 1'b0;
                            prog_next   = '0;
                        end
                        KIND_LINE:
                        begin
                            pend_next = in_count;
                            pacc_next = (lines_reg < CW'(MAX_LINES));
                            if (lines_reg < CW'(MAX_LINES))
                            begin
                                lram_we       = 1'b1;
                                lram_waddr    = LW'(lines_reg);
                                lram_wdata    = {TCW'(0), tokens_reg, in_end, in_start};
                                ld_start_next = in_start;
                                ld_end_next   = in_end;
                                ld_base_next  = tokens_reg;
                                ld_tot_next   = '0;
                                lines_next    = lines_reg + 1'b1;
                            end
                        end
                        KIND_TOKEN:
                        begin
                            if (pend_reg != '0)
                            begin
                                pend_next = pend_reg - 1'b1;
                                if (pacc_reg && lines_reg != '0
                                    && tokens_reg < TCW'(MAX_TOKENS))
                                begin
                                    tram_we     = 1'b1;
                                    tram_waddr  = TKW'(tokens_reg);
                                    tram_wdata  = {in_end, in_start};
                                    tokens_next = tokens_reg + 1'b1;
                                    ld_tot_next = ld_tot_reg + 1'b1;
                                    // rewrite the last line with its new token total
                                    lram_we     = 1'b1;
                                    lram_waddr  = LW'(lines_reg - 1'b1);
                                    lram_wdata  = {ld_tot_reg + 1'b1, ld_base_reg,
                                                   ld_end_reg, ld_start_reg};
                                end
                            end
                        end
                        KIND_FINISH:
                        begin
                            lo_next = '0;
                            if (lines_reg != '0)
                            begin
                                state_next = ST_F_LRD;
                            end
                            else
                            begin
                                cline_next = '0;
                                clv_next   = 1'b0;
                                ctok_next  = '0;
                                ctv_next   = 1'b0;
                                prog_next  = '0;
                            end
                        end
                        KIND_POS:
                        begin
                            pos_next   = in_pos;
                            found_next = 1'b0;
                            chg_next   = 1'b0;
                            lo_next    = '0;
                            hi_next    = lines_reg;
                            state_next = (lines_reg == '0) ? ST_P_OUT : ST_P_LPROBE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // ---------------- finish sweep ----------------
            ST_F_LRD:
            begin
                lram_re    = 1'b1;
                lram_raddr = LW'(lo_reg);
                state_next = ST_F_LCAP;
            end
            ST_F_LCAP:
            begin
                l_start_next = lr_start;
                l_end_next   = lr_end;
                l_base_next  = lr_base;
                l_tot_next   = lr_tot;
                if (lo_inc < lines_reg)
                begin
                    lram_re    = 1'b1;
                    lram_raddr = LW'(lo_inc);
                    state_next = ST_F_NCAP;
                end
                else
                begin
                    state_next = ST_F_LFIX;
                end
            end
            ST_F_NCAP:
            begin
                n_start_next = lr_start;
                state_next   = ST_F_LFIX;
            end
            ST_F_LFIX:
            begin
                alu_a = W'(l_start_reg);
                alu_b = W'(l_end_reg);
                if (alu_flag)
                begin
                    state_next = ST_F_TINIT;
                end
                else if (lo_inc < lines_reg)
                begin
                    l_end_next = n_start_reg;
                    lram_we    = 1'b1;
                    lram_waddr = LW'(lo_reg);
                    lram_wdata = {l_tot_reg, l_base_reg, n_start_reg, l_start_reg};
                    state_next = ST_F_TINIT;
                end
                else
                begin
                    state_next = ST_F_LADD;
                end
            end
            ST_F_LADD:
            begin
                alu_op      = ALU_ADD;
                alu_a       = W'(l_start_reg);
                alu_b       = W'(span_reg);
                l_end_next  = sat_sum;
                ld_end_next = sat_sum;
                lram_we     = 1'b1;
                lram_waddr  = LW'(lo_reg);
                lram_wdata  = {l_tot_reg, l_base_reg, sat_sum, l_start_reg};
                state_next  = ST_F_TINIT;
            end
            ST_F_TINIT:
            begin
                tlo_next   = '0;
                state_next = (l_tot_reg == '0) ? ST_F_LNEXT : ST_F_TRD;
            end
            ST_F_TRD:
            begin
                tram_re    = 1'b1;
                tram_raddr = tok_addr;
                state_next = ST_F_TCAP;
            end
            ST_F_TCAP:
            begin
                t_start_next = tr_start;
                t_end_next   = tr_end;
                if (tlo_inc < l_tot_reg)
                begin
                    tram_re    = 1'b1;
                    tram_raddr = tok_addr + 1'b1;
                    state_next = ST_F_TNCAP;
                end
                else
                begin
                    state_next = ST_F_TFIX;
                end
            end
            ST_F_TNCAP:
            begin
                n_start_next = tr_start;
                state_next   = ST_F_TFIX;
            end
            ST_F_TFIX:
            begin
                alu_a = W'(t_start_reg);
                alu_b = W'(t_end_reg);
                if (alu_flag)
                begin
                    state_next = ST_F_TNEXT;
                end
                else
                begin
                    t_end_next = (tlo_inc < l_tot_reg) ? n_start_reg : l_end_reg;
                    state_next = ST_F_TCHK;
                end
            end
            ST_F_TCHK:
            begin
                alu_a = W'(t_start_reg);
                alu_b = W'(t_end_reg);
                if (alu_flag)
                begin
                    tram_we    = 1'b1;
                    tram_waddr = tok_addr;
                    tram_wdata = {t_end_reg, t_start_reg};
                    state_next = ST_F_TNEXT;
                end
                else
                begin
                    state_next = ST_F_TADD;
                end
            end
            ST_F_TADD:
            begin
                alu_op     = ALU_ADD;
                alu_a      = W'(t_start_reg);
                alu_b      = W'(1);
                tram_we    = 1'b1;
                tram_waddr = tok_addr;
                tram_wdata = {sat_sum, t_start_reg};
                state_next = ST_F_TNEXT;
            end
            ST_F_TNEXT:
            begin
                if (tlo_inc < l_tot_reg)
                begin
                    tlo_next   = tlo_inc;
                    state_next = ST_F_TRD;
                end
                else
                begin
                    state_next = ST_F_LNEXT;
                end
            end
            ST_F_LNEXT:
            begin
                if (lo_inc < lines_reg)
                begin
                    lo_next    = lo_inc;
                    state_next = ST_F_LRD;
                end
                else
                begin
                    cline_next = '0;
                    clv_next   = 1'b0;
                    ctok_next  = '0;
                    ctv_next   = 1'b0;
                    prog_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            // ---------------- position lookup ----------------
            ST_P_LPROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = ST_P_OUT;
                end
                else
                begin
                    mid_next   = LW'(lmid_w);
                    lram_re    = 1'b1;
                    lram_raddr = LW'(lmid_w);
                    state_next = ST_P_LCAP;
                end
            end
            ST_P_LCAP:
            begin
                l_start_next = lr_start;
                l_end_next   = lr_end;
                l_base_next  = lr_base;
                l_tot_next   = lr_tot;
                state_next   = ST_P_LC1;
            end
            ST_P_LC1:
            begin
                alu_a = W'(pos_reg);
                alu_b = W'(l_start_reg);
                if (alu_flag)
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = ST_P_LPROBE;
                end
                else
                begin
                    state_next = ST_P_LC2;
                end
            end
            ST_P_LC2:
            begin
                alu_a = W'(pos_reg);
                alu_b = W'(l_end_reg);
                if (alu_flag)
                begin
                    state_next = ST_P_LHIT;
                end
                else
                begin
                    lo_next    = CW'(mid_reg) + 1'b1;
                    state_next = ST_P_LPROBE;
                end
            end
            ST_P_LHIT:
            begin
                found_next = 1'b1;
                if (!clv_reg || cline_reg != mid_reg)
                begin
                    cline_next = mid_reg;
                    clv_next   = 1'b1;
                    ctok_next  = '0;
                    ctv_next   = 1'b0;
                    prog_next  = '0;
                    chg_next   = 1'b1;
                end
                tlo_next = '0;
                thi_next = l_tot_reg;
                if (l_tot_reg == '0)
                begin
                    ctok_next  = '0;
                    ctv_next   = 1'b0;
                    prog_next  = '0;
                    state_next = ST_P_OUT;
                end
                else
                begin
                    state_next = ST_P_TPROBE;
                end
            end
            ST_P_TPROBE:
            begin
                if (tlo_reg >= thi_reg)
                begin
                    state_next = ST_P_OUT;
                end
                else
                begin
                    tmid_next  = TKW'(tmid_w);
                    tram_re    = 1'b1;
                    tram_raddr = TKW'(l_base_reg + TCW'(tmid_w));
                    state_next = ST_P_TCAP;
                end
            end
            ST_P_TCAP:
            begin
                t_start_next = tr_start;
                t_end_next   = tr_end;
                state_next   = ST_P_TC1;
            end
            ST_P_TC1:
            begin
                alu_a = W'(pos_reg);
                alu_b = W'(t_start_reg);
                if (alu_flag)
                begin
                    thi_next   = TCW'(tmid_reg);
                    state_next = ST_P_TPROBE;
                end
                else
                begin
                    state_next = ST_P_TC2;
                end
            end
            ST_P_TC2:
            begin
                alu_a = W'(pos_reg);
                alu_b = W'(t_end_reg);
                if (alu_flag)
                begin
                    state_next = ST_P_DNUM;
                end
                else
                begin
                    tlo_next   = TCW'(tmid_reg) + 1'b1;
                    state_next = ST_P_TPROBE;
                end
            end
            ST_P_DNUM:
            begin
                alu_a      = W'(pos_reg);
                alu_b      = W'(t_start_reg);
                rem_next   = alu_res;
                state_next = ST_P_DDEN;
            end
            ST_P_DDEN:
            begin
                alu_a      = W'(t_end_reg);
                alu_b      = W'(t_start_reg);
                den_next   = alu_res[TB-1:0];
                q_next     = '0;
                dcnt_next  = '0;
                state_next = ST_P_DSTEP;
            end
            ST_P_DSTEP:
            begin
                // restoring divide, one quotient bit per cycle
                alu_a = rem2;
                alu_b = W'(den_reg);
                if (!alu_flag)
                begin
                    rem_next = alu_res;
                    q_next   = {q_reg[PB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    q_next   = {q_reg[PB-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(PB - 1))
                begin
                    state_next = ST_P_DTOK;
                end
            end
            ST_P_DTOK:
            begin
                ctok_next = tmid_reg;
                ctv_next  = 1'b1;
                if ((PB + 16)'(pdiff) > (PB + 16)'(dband_reg))
                begin
                    prog_next = q_reg;
                end
                state_next = ST_P_OUT;
            end
            ST_P_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {1'b0, 16'(prog_reg), 12'(ctok_reg), ctv_reg,
                                  chg_reg, 8'(cline_reg), found_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            lines_reg  <= '0;
            tokens_reg <= '0;
            pend_reg   <= '0;
            pacc_reg   <= 1'b0;
            span_reg   <= RST_LINE_SPAN;
            dband_reg  <= RST_DEADBAND;
            cline_reg  <= '0;
            clv_reg    <= 1'b0;
            ctok_reg   <= '0;
            ctv_reg    <= 1'b0;
            prog_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            tlo_reg    <= '0;
            thi_reg    <= '0;
            dcnt_reg   <= '0;
            found_reg  <= 1'b0;
            chg_reg    <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lines_reg  <= lines_next;
            tokens_reg <= tokens_next;
            pend_reg   <= pend_next;
            pacc_reg   <= pacc_next;
            span_reg   <= span_next;
            dband_reg  <= dband_next;
            cline_reg  <= cline_next;
            clv_reg    <= clv_next;
            ctok_reg   <= ctok_next;
            ctv_reg    <= ctv_next;
            prog_reg   <= prog_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            tlo_reg    <= tlo_next;
            thi_reg    <= thi_next;
            dcnt_reg   <= dcnt_next;
            found_reg  <= found_next;
            chg_reg    <= chg_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        ld_start_reg <= ld_start_next;
        ld_end_reg   <= ld_end_next;
        ld_base_reg  <= ld_base_next;
        ld_tot_reg   <= ld_tot_next;
        mid_reg      <= mid_next;
        tmid_reg     <= tmid_next;
        l_start_reg  <= l_start_next;
        l_end_reg    <= l_end_next;
        l_base_reg   <= l_base_next;
        l_tot_reg    <= l_tot_next;
        n_start_reg  <= n_start_next;
        t_start_reg  <= t_start_next;
        t_end_reg    <= t_end_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        q_reg        <= q_next;
        md_reg       <= md_next;
    end

    a_lines_cap: assert property (@(posedge clk) disable iff (!rst_n)
        lines_reg <= CW'(MAX_LINES))
        else $error("line count beyond capacity");

    a_tokens_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tokens_reg <= TCW'(MAX_TOKENS))
        else $error("token count beyond capacity");

    a_token_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        ctv_reg |-> clv_reg)
        else $error("current token held without a current line");

    a_result_only_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mv_reg) |-> $past(state_reg) == ST_P_OUT)
        else $error("result raised outside the output step");
endmodule

// File: tb/til_checker.sv
// Scoreboard for the timed interval locator: watches the input, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on til_pkg.
`timescale 1ns / 1ps

module til_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [til_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [til_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [til_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [til_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [til_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             pending
);
    import til_pkg::*;

    localparam int NLINES  = DEF_MAX_LINES;
    localparam int NTOKENS = DEF_MAX_TOKENS;

    // highest field first, so that found lands in bit 0
    typedef struct packed {
        logic [15:0] progress;
        logic [11:0] tok_idx;
        logic        tok_valid;
        logic        changed;
        logic [7:0]  line_idx;
        logic        found;
    } loc_result_t;

    logic [31:0] ln_start [NLINES];
    logic [31:0] ln_end   [NLINES];
    int          ln_base  [NLINES];
    int          ln_total [NLINES];
    logic [31:0] tk_start [NTOKENS];
    logic [31:0] tk_end   [NTOKENS];

    int          n_lines, n_tokens, tokens_owed;
    bit          owed_accept;
    int          cur_line, cur_tok;
    bit          cur_line_ok, cur_tok_ok;
    logic [15:0] held_progress;
    logic [15:0] line_span, deadband;

    loc_result_t expected_q[$];

    function automatic void drop_position();
        cur_line      = 0;
        cur_line_ok   = 0;
        cur_tok       = 0;
        cur_tok_ok    = 0;
        held_progress = '0;
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Binary search over either the line table or one line's token run.
    function automatic int find_span(bit tok, int base, int n, logic [31:0] p);
        int          lo, hi, mid;
        logic [31:0] s, e;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            s = tok ? tk_start[base + mid] : ln_start[mid];
            e = tok ? tk_end[base + mid]   : ln_end[mid];
            if (p < s)
                hi = mid - 1;
            else if (p >= e)
                lo = mid + 1;
            else
                return mid;
        end
        return -1;
    endfunction

    function automatic void repair_ends();
        int k;
        for (int i = 0; i < n_lines; i++) begin
            if (ln_end[i] <= ln_start[i])
                ln_end[i] = (i + 1 < n_lines) ? ln_start[i + 1]
                                              : sat_sum(ln_start[i], {16'b0, line_span});
            for (int j = 0; j < ln_total[i]; j++) begin
                k = ln_base[i] + j;
                if (k >= NTOKENS)
                    break;
                if (tk_end[k] <= tk_start[k]) begin
                    if (j + 1 < ln_total[i] && k + 1 < NTOKENS)
                        tk_end[k] = tk_start[k + 1];
                    else
                        tk_end[k] = ln_end[i];
                    if (tk_end[k] <= tk_start[k])
                        tk_end[k] = sat_sum(tk_start[k], 32'd1);
                end
            end
        end
        drop_position();
    endfunction

    function automatic loc_result_t locate(logic [31:0] p);
        loc_result_t r;
        int          li, ti, base, tot, k, diff;
        logic [31:0] s, e;
        logic [63:0] q;
        logic [15:0] frac;
        r = '0;
        if (n_lines > 0) begin
            li = find_span(0, 0, n_lines, p);
            if (li >= 0) begin
                r.found = 1;
                if (!cur_line_ok || cur_line != li) begin
                    cur_line      = li;
                    cur_line_ok   = 1;
                    cur_tok       = 0;
                    cur_tok_ok    = 0;
                    held_progress = '0;
                    r.changed     = 1;
                end
                base = ln_base[cur_line];
                tot  = ln_total[cur_line];
                if (base > NTOKENS)
                    base = NTOKENS;
                if (tot > NTOKENS - base)
                    tot = NTOKENS - base;
                if (tot == 0) begin
                    cur_tok       = 0;
                    cur_tok_ok    = 0;
                    held_progress = '0;
                end else begin
                    ti = find_span(1, base, tot, p);
                    if (ti >= 0) begin
                        k = base + ti;
                        s = tk_start[k];
                        e = tk_end[k];
                        frac = '0;
                        if (e > s) begin
                            if (p - s >= e - s)
                                frac = 16'hFFFF;
                            else begin
                                q = ({32'b0, p - s} << 16) / {32'b0, e - s};
                                frac = q[15:0];
                            end
                        end
                        diff = (frac > held_progress) ? int'(frac) - int'(held_progress)
                                                      : int'(held_progress) - int'(frac);
                        cur_tok    = ti;
                        cur_tok_ok = 1;
                        if (diff > int'(deadband))
                            held_progress = frac;
                    end
                end
            end
        end
        r.line_idx  = cur_line[7:0];
        r.tok_valid = cur_tok_ok;
        r.tok_idx   = cur_tok[11:0];
        r.progress  = held_progress;
        return r;
    endfunction

    function automatic void apply_item(logic [KIND_W-1:0] kind, logic [31:0] ts,
                                       logic [31:0] te, logic [12:0] cnt,
                                       logic [31:0] p);
        case (kind)
            KIND_CLEAR: begin
                n_lines     = 0;
                n_tokens    = 0;
                tokens_owed = 0;
                owed_accept = 0;
                drop_position();
            end
            KIND_LINE: begin
                tokens_owed = cnt;
                owed_accept = n_lines < NLINES;
                if (owed_accept) begin
                    ln_start[n_lines] = ts;
                    ln_end[n_lines]   = te;
                    ln_base[n_lines]  = n_tokens;
                    ln_total[n_lines] = 0;
                    n_lines++;
                end
            end
            KIND_TOKEN: begin
                if (tokens_owed > 0) begin
                    tokens_owed--;
                    if (owed_accept && n_lines > 0 && n_tokens < NTOKENS) begin
                        tk_start[n_tokens] = ts;
                        tk_end[n_tokens]   = te;
                        n_tokens++;
                        ln_total[n_lines - 1]++;
                    end
                end
            end
            KIND_FINISH: repair_ends();
            KIND_POS:    expected_q.push_back(locate(p));
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        loc_result_t want, got;
        if (!rst_n) begin
            n_lines     = 0;
            n_tokens    = 0;
            tokens_owed = 0;
            owed_accept = 0;
            drop_position();
            line_span   = RST_LINE_SPAN;
            deadband    = RST_DEADBAND;
            expected_q.delete();
            errors      = 0;
            pending     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = loc_result_t'(m_tdata[38:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("line_found",   want.found,     got.found);
                    check_field("line_index",   want.line_idx,  got.line_idx);
                    check_field("line_changed", want.changed,   got.changed);
                    check_field("token_valid",  want.tok_valid, got.tok_valid);
                    check_field("token_index",  want.tok_idx,   got.tok_idx);
                    check_field("progress",     want.progress,  got.progress);
                end
            end
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[76:64],
                           s_tdata[108:77]);
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_LINE_SPAN)
                    line_span = cfg_wdata;
                else if (cfg_addr == CFG_DEADBAND)
                    deadband = cfg_wdata;
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top for the timed interval locator: clock, reset, stimulus and
// verdict. Depends on til_pkg, timed_interval_locator and til_checker.
`timescale 1ns / 1ps

module tb;
    import til_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          errors, pending;
    int          cycles = 0;
    bit          no_gaps = 0;
    bit          hold_req = 0;
    logic [31:0] span_lo, span_hi, last_pos;

    always #2 clk = ~clk;

    timed_interval_locator u_dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata
    );

    til_checker u_checker (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .errors, .pending
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 0;
            end else if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1;
                m_tready <= 0;
            end else
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send(logic [KIND_W-1:0] kind, logic [31:0] ts, logic [31:0] te,
                        logic [12:0] cnt, logic [31:0] p);
        if (!no_gaps && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, p, cnt, te, ts};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drain all results and let any sweep finish before touching registers.
    task automatic settle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_timeline(int nl, logic [31:0] t0);
        logic [31:0] t, st, en, ts, te;
        int          len, nt, ann, tl;
        t = t0;
        send(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < nl; i++) begin
            if ($urandom_range(0, 19) == 0)
                send(KIND_UNUSED_FIRST + $urandom_range(0, 2), $urandom, $urandom, 0, $urandom);
            st  = t;
            len = $urandom_range(50, 4000);
            if ($urandom_range(0, 3) == 0)
                en = $urandom_range(0, 1) ? 32'd0 : st;
            else
                en = st + len;
            nt  = $urandom_range(0, 6);
            ann = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : nt;
            if ($urandom_range(0, 39) == 0)
                ann = $urandom_range(0, 4096);
            send(KIND_LINE, st, en, ann[12:0], $urandom);
            ts = st;
            for (int j = 0; j < nt; j++) begin
                tl = $urandom_range(1, len / nt + 1);
                te = ($urandom_range(0, 3) == 0) ? 32'd0 : ts + tl;
                send(KIND_TOKEN, ts, te, $urandom, $urandom);
                ts = ts + tl + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
            end
            t = st + len + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 500) : 0);
        end
        send(KIND_FINISH, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 9) == 0)
            send(KIND_FINISH, 0, 0, 0, 0);
        span_lo  = t0;
        span_hi  = (t + 66000 < t) ? 32'hFFFF_FFFF : t + 66000;
        last_pos = t0;
    endtask

    // Mostly small forward steps so that the deadband logic gets exercised.
    task automatic play_positions(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                last_pos = last_pos + $urandom_range(0, 60);
                if (last_pos > span_hi || last_pos < span_lo)
                    last_pos = span_lo;
            end else if (r < 9)
                last_pos = $urandom_range(span_lo, span_hi);
            else
                last_pos = $urandom;
            send(KIND_POS, $urandom, $urandom, $urandom, last_pos);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: empty timeline, stray tokens, unused kinds, missing ends.
        send(KIND_POS, 0, 0, 0, 0);
        send(KIND_TOKEN, 5, 9, 0, 0);
        send(KIND_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);
        send(KIND_UNUSED_FIRST + 3'd2, 0, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0, 0);
        send(KIND_LINE, 0, 0, 13'd4096, 0);
        send(KIND_TOKEN, 0, 0, 0, 0);
        send(KIND_TOKEN, 10, 5, 0, 0);
        send(KIND_LINE, 100, 300, 2, 0);
        send(KIND_TOKEN, 100, 200, 0, 0);
        send(KIND_TOKEN, 250, 0, 0, 0);
        send(KIND_TOKEN, 260, 270, 0, 0);
        send(KIND_LINE, 32'hFFFF_E000, 0, 1, 0);
        send(KIND_TOKEN, 32'hFFFF_FFF0, 0, 0, 0);
        send(KIND_FINISH, 0, 0, 0, 0);
        send(KIND_FINISH, 0, 0, 0, 0);
        send(KIND_POS, 0, 0, 0, 0);
        send(KIND_POS, 0, 0, 0, 5);
        send(KIND_POS, 0, 0, 0, 150);
        send(KIND_POS, 0, 0, 0, 199);
        send(KIND_POS, 0, 0, 0, 230);
        send(KIND_POS, 0, 0, 0, 299);
        send(KIND_POS, 0, 0, 0, 400);
        send(KIND_POS, 0, 0, 0, 32'hFFFF_E000);
        send(KIND_POS, 0, 0, 0, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 30; ph++) begin
            settle();
            case (ph % 5)
                1: begin write_reg(CFG_LINE_SPAN, 16'd1);     write_reg(CFG_DEADBAND, 16'd0);     end
                2: begin write_reg(CFG_LINE_SPAN, 16'hFFFF);  write_reg(CFG_DEADBAND, 16'hFFFF);  end
                3: begin write_reg(CFG_LINE_SPAN, $urandom_range(1, 65535));
                         write_reg(CFG_DEADBAND, $urandom_range(0, 2000)); end
                4: begin write_reg(CFG_LINE_SPAN, RST_LINE_SPAN); write_reg(CFG_DEADBAND, 16'd1); end
                default: ;
            endcase
            cfg_wr_en <= 0;
            no_gaps = (ph == 7 || ph == 8);
            if (ph == 15) begin
                // Overfill the line table: late lines and their tokens are dropped.
                send(KIND_CLEAR, 0, 0, 0, 0);
                for (int i = 0; i < 260; i++) begin
                    send(KIND_LINE, i * 1000, 0, (i % 4 == 0) ? 13'd1 : 13'd0, 0);
                    if (i % 4 == 0)
                        send(KIND_TOKEN, i * 1000 + 60, (i % 8 == 0) ? 0 : i * 1000 + 110,
                             0, 0);
                end
                send(KIND_FINISH, 0, 0, 0, 0);
                span_lo  = 0;
                span_hi  = 262000;
                last_pos = 0;
            end else if (ph % 6 == 5)
                load_timeline($urandom_range(1, 4), 32'hFFFF_0000 + $urandom_range(0, 61000));
            else
                load_timeline($urandom_range(1, 12), $urandom_range(0, 32'hF000_0000));
            if (ph == 4)
                hold_req = 1;
            play_positions(25);
        end

        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/til_pkg.sv
rtl/til_ram.sv
rtl/til_alu.sv
rtl/timed_interval_locator.sv
tb/til_checker.sv
tb/tb.sv
